// ===== sv/midi_trigger_event_coalescer_top_assert.svh =====
// Assertion macros used by the event coalescer controller.
`ifndef MIDI_TRIGGER_EVENT_COALESCER_TOP_ASSERT_SVH
`define MIDI_TRIGGER_EVENT_COALESCER_TOP_ASSERT_SVH

`ifndef SYNTH

`define MTEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mtec: implication check failed");

`define MTEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mtec: next-cycle check failed");

`else

`define MTEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define MTEC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/mtec_pkg.sv =====
// Shared types and constants of the MIDI trigger event coalescer.
package mtec_pkg;

  localparam int unsigned STORE_DEPTH     = 32;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd64;

  localparam logic        CMD_PUSH  = 1'b0;
  localparam logic        CMD_FLUSH = 1'b1;

  localparam logic [1:0]  KIND_CC   = 2'd0;
  localparam logic [1:0]  KIND_PC   = 2'd1;
  localparam logic [1:0]  KIND_NOTE = 2'd2;

  localparam logic [3:0]  MSG_NOTE_ON = 4'h9;
  localparam logic [3:0]  MSG_CC      = 4'hB;
  localparam logic [3:0]  MSG_PC      = 4'hC;

  // One stored event: channel kept as channel minus one.
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] chan;
    logic [6:0] num;
    logic [6:0] val;
  } mtec_ev_t;

  typedef struct packed {
    logic push;
    logic flush_start;
    logic srch_start;
    logic srch_step;
    logic append;
    logic overwrite;
    logic advance;
    logic emit_start;
    logic emit_load;
    logic emit_step;
  } mtec_cmd_t;

  typedef struct packed {
    logic pcnt_zero;
    logic mcnt_zero;
    logic cur_is_cc;
    logic hit;
    logic same_side;
    logic j_zero;
    logic i_last;
    logic k_last;
  } mtec_sts_t;

endpackage

// ===== sv/mtec_dp.sv =====
// Datapath: pending and merged stores, counters, threshold and result register.
module mtec_dp import mtec_pkg::*; #(
  parameter int unsigned Depth = STORE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic [7:0] status_byte_i,
  input  logic [6:0] data_one_i,
  input  logic [6:0] data_two_i,
  input  mtec_cmd_t  ctl_i,
  output mtec_sts_t  sts_o,
  output logic [1:0] event_kind_o,
  output logic [4:0] event_channel_o,
  output logic [6:0] event_number_o,
  output logic [6:0] event_value_o,
  output logic       last_event_o
);

  localparam int unsigned IW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  mtec_ev_t pend_mem [Depth];
  mtec_ev_t merg_mem [Depth];

  mtec_ev_t pend_rd_q, merg_rd_q, out_q;
  logic     last_q;
  logic [7:0]    thr_q;
  logic [CW-1:0] pcnt_q, mcnt_q;
  logic [IW-1:0] i_q, j_q, k_q;

  mtec_ev_t      push_ev;
  logic          push_keep;
  logic          pend_we, pend_re, merg_we, merg_re;
  logic [IW-1:0] pend_raddr, merg_waddr, merg_raddr;

  // Decode the raw message into a stored event.
  always_comb begin
    push_ev.kind = KIND_CC;
    push_ev.chan = status_byte_i[3:0];
    push_ev.num  = data_one_i;
    push_ev.val  = data_two_i;
    push_keep    = 1'b0;
    case (status_byte_i[7:4])
      MSG_CC: begin
        push_ev.kind = KIND_CC;
        push_keep    = 1'b1;
      end
      MSG_PC: begin
        push_ev.kind = KIND_PC;
        push_ev.val  = '0;
        push_keep    = 1'b1;
      end
      MSG_NOTE_ON: begin
        push_ev.kind = KIND_NOTE;
        push_keep    = (data_two_i != '0);
      end
      default: push_keep = 1'b0;
    endcase
  end

  assign pend_we    = ctl_i.push && push_keep && (pcnt_q != CW'(Depth));
  assign pend_re    = ctl_i.flush_start || ctl_i.advance;
  assign pend_raddr = ctl_i.flush_start ? '0 : i_q + IW'(1);

  assign merg_we    = ctl_i.append || ctl_i.overwrite;
  assign merg_waddr = ctl_i.overwrite ? j_q : mcnt_q[IW-1:0];
  assign merg_re    = ctl_i.srch_start || ctl_i.srch_step ||
                      ctl_i.emit_start || ctl_i.emit_step;

  always_comb begin
    merg_raddr = '0;
    if (ctl_i.srch_start) begin
      merg_raddr = mcnt_q[IW-1:0] - IW'(1);
    end else if (ctl_i.srch_step) begin
      merg_raddr = j_q - IW'(1);
    end else if (ctl_i.emit_step) begin
      merg_raddr = k_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_mem[pcnt_q[IW-1:0]] <= push_ev;
    end
    if (pend_re) begin
      pend_rd_q <= pend_mem[pend_raddr];
    end
  end

  // Overwrite writes the whole current event: kind, channel and number match.
  always_ff @(posedge clk_i) begin
    if (merg_we) begin
      merg_mem[merg_waddr] <= pend_rd_q;
    end
    if (merg_re) begin
      merg_rd_q <= merg_mem[merg_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit_load) begin
      out_q  <= merg_rd_q;
      last_q <= sts_o.k_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THRESHOLD_RESET;
      pcnt_q <= '0;
      mcnt_q <= '0;
      i_q    <= '0;
      j_q    <= '0;
      k_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (pend_we) begin
        pcnt_q <= pcnt_q + CW'(1);
      end else if (ctl_i.emit_start) begin
        pcnt_q <= '0;
      end
      if (ctl_i.flush_start) begin
        mcnt_q <= '0;
        i_q    <= '0;
      end else begin
        if (ctl_i.append) begin
          mcnt_q <= mcnt_q + CW'(1);
        end
        if (ctl_i.advance) begin
          i_q <= i_q + IW'(1);
        end
      end
      if (ctl_i.srch_start) begin
        j_q <= mcnt_q[IW-1:0] - IW'(1);
      end else if (ctl_i.srch_step) begin
        j_q <= j_q - IW'(1);
      end
      if (ctl_i.emit_start) begin
        k_q <= '0;
      end else if (ctl_i.emit_step) begin
        k_q <= k_q + IW'(1);
      end
    end
  end

  assign sts_o.pcnt_zero = (pcnt_q == '0);
  assign sts_o.mcnt_zero = (mcnt_q == '0);
  assign sts_o.cur_is_cc = (pend_rd_q.kind == KIND_CC);
  assign sts_o.hit       = (merg_rd_q.kind == KIND_CC) &&
                           (merg_rd_q.chan == pend_rd_q.chan) &&
                           (merg_rd_q.num == pend_rd_q.num);
  assign sts_o.same_side = (({1'b0, merg_rd_q.val} >= thr_q) ==
                            ({1'b0, pend_rd_q.val} >= thr_q));
  assign sts_o.j_zero    = (j_q == '0);
  assign sts_o.i_last    = ((CW'(i_q) + CW'(1)) == pcnt_q);
  assign sts_o.k_last    = ((CW'(k_q) + CW'(1)) == mcnt_q);

  assign event_kind_o    = out_q.kind;
  assign event_channel_o = {1'b0, out_q.chan} + 5'd1;
  assign event_number_o  = out_q.num;
  assign event_value_o   = out_q.val;
  assign last_event_o    = last_q;

endmodule

// ===== sv/mtec_ctrl.sv =====
// Controller: sequences push, coalescing walk and result emission.
module mtec_ctrl import mtec_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      cmd_i,
  input  logic      out_ready_i,
  input  mtec_sts_t sts_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output mtec_cmd_t ctl_o
);

`include "midi_trigger_event_coalescer_top_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SRCH,
    ST_NEXT,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctl_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == CMD_PUSH) begin
            ctl_o.push = 1'b1;
          end else if (!sts_i.pcnt_zero) begin
            ctl_o.flush_start = 1'b1;
            state_d           = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (sts_i.cur_is_cc && !sts_i.mcnt_zero) begin
          ctl_o.srch_start = 1'b1;
          state_d          = ST_SRCH;
        end else begin
          ctl_o.append = 1'b1;
          state_d      = ST_NEXT;
        end
      end
      ST_SRCH: begin
        // Walk back to the newest control change on the same channel and number.
        if (sts_i.hit) begin
          ctl_o.overwrite = sts_i.same_side;
          ctl_o.append    = !sts_i.same_side;
          state_d         = ST_NEXT;
        end else if (sts_i.j_zero) begin
          ctl_o.append = 1'b1;
          state_d      = ST_NEXT;
        end else begin
          ctl_o.srch_step = 1'b1;
        end
      end
      ST_NEXT: begin
        if (sts_i.i_last) begin
          ctl_o.emit_start = 1'b1;
          state_d          = ST_EMIT_LD;
        end else begin
          ctl_o.advance = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EMIT_LD: begin
        ctl_o.emit_load = 1'b1;
        out_valid_d     = 1'b1;
        state_d         = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (sts_i.k_last) begin
            state_d = ST_IDLE;
          end else begin
            ctl_o.emit_step = 1'b1;
            state_d         = ST_EMIT_LD;
          end
        end
      end
      default: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `MTEC_ASSERT_IMPLY(a_no_input_while_result, clk_i, rst_ni, in_ready_o, !out_valid_q)
  `MTEC_ASSERT_NEXT(a_last_frees_input, clk_i, rst_ni, out_valid_q && out_ready_i && sts_i.k_last, in_ready_o)
  `MTEC_ASSERT_NEXT(a_hit_ends_search, clk_i, rst_ni, (state_q == ST_SRCH) && sts_i.hit, state_q == ST_NEXT)
  `MTEC_ASSERT_NEXT(a_empty_flush_silent, clk_i, rst_ni, in_ready_o && in_valid_i && (cmd_i == CMD_FLUSH) && sts_i.pcnt_zero, in_ready_o && !out_valid_q)

endmodule

// ===== sv/midi_trigger_event_coalescer_top.sv =====
// MIDI trigger event coalescer: usage notes and operation.
//
// Input channel (in_valid_i/in_ready_o) carries items: cmd_i = push takes one raw
// MIDI message (status_byte_i, data_one_i, data_two_i); cmd_i = flush drains the
// pending store. Only control change, program change and note-on with nonzero
// velocity are stored; the rest, and pushes into a full store, are dropped.
// A push leaves the block idle, so it is ready again for the next item.
// A flush of N stored events walks the pending store one event at a time; a
// control change scans the merged store backward, one entry per cycle, through
// the single read port of that memory. Each event is appended, or overwrites the
// entry it matches; after the last event the first item is loaded for output.
// Output channel (out_valid_o/out_ready_i) gives one coalesced event at a time
// while the receiver is ready; last_event_o marks the final one. A stalled
// receiver holds the current item and the walk; no input is taken until the
// final item of the flush is accepted. A flush of an empty store gives nothing.
// cfg_we_i/cfg_wdata_i write press_threshold (reset 64); write only when idle.
// Reset empties both stores at once (counts cleared) and returns to idle.
module midi_trigger_event_coalescer_top import mtec_pkg::*; #(
  parameter int unsigned StoreDepth = STORE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] status_byte_i,
  input  logic [6:0] data_one_i,
  input  logic [6:0] data_two_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] event_kind_o,
  output logic [4:0] event_channel_o,
  output logic [6:0] event_number_o,
  output logic [6:0] event_value_o,
  output logic       last_event_o
);

  mtec_cmd_t ctl;
  mtec_sts_t sts;

  mtec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .ctl_o       (ctl)
  );

  mtec_dp #(
    .Depth (StoreDepth)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .status_byte_i   (status_byte_i),
    .data_one_i      (data_one_i),
    .data_two_i      (data_two_i),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .event_kind_o    (event_kind_o),
    .event_channel_o (event_channel_o),
    .event_number_o  (event_number_o),
    .event_value_o   (event_value_o),
    .last_event_o    (last_event_o)
  );

endmodule

// ===== test/midi_trigger_event_coalescer_top_tb.sv =====
// Testbench for the MIDI trigger event coalescer: directed and random pushes and flushes checked by a scoreboard.
module midi_trigger_event_coalescer_top_tb;
  import mtec_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_PHASE    = 3;
  localparam int RANDOM_ITEMS  = 120;
  localparam int TIMEOUT       = 4000000;

  typedef enum int {RX_STEADY, RX_HALF, RX_SPARSE} rx_mode_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] channel;
    logic [6:0] number;
    logic [6:0] value;
  } trig_event_t;

  typedef struct packed {
    trig_event_t ev;
    logic        last;
  } flush_result_t;

  class coalesce_scoreboard;
    logic [7:0]    threshold;
    trig_event_t   held[$];
    flush_result_t awaited[$];
    int            errors;

    function new();
      threshold = THRESHOLD_RESET;
      errors = 0;
    endfunction

    function bit pressed(logic [6:0] v);
      return {1'b0, v} >= threshold;
    endfunction

    function void note_input(logic cmd, logic [7:0] status, logic [6:0] d1, logic [6:0] d2);
      trig_event_t   ev;
      trig_event_t   merged[$];
      flush_result_t res;
      bit            absorbed;
      int            i;
      if (cmd == CMD_PUSH) begin
        ev.channel = {1'b0, status[3:0]} + 5'd1;
        ev.number = d1;
        ev.value = d2;
        case (status[7:4])
          MSG_CC: ev.kind = KIND_CC;
          MSG_PC: begin
            ev.kind = KIND_PC;
            ev.value = '0;
          end
          MSG_NOTE_ON: begin
            if (d2 == 7'd0) return;
            ev.kind = KIND_NOTE;
          end
          default: return;
        endcase
        // drop when the store is full
        if (held.size() < STORE_DEPTH) held = {held, ev};
        return;
      end
      foreach (held[n]) begin
        absorbed = 0;
        if (held[n].kind == KIND_CC) begin
          // scan back to the newest control change on the same channel and number
          for (i = merged.size() - 1; i >= 0; i--) begin
            if (merged[i].kind == KIND_CC && merged[i].channel == held[n].channel &&
                merged[i].number == held[n].number) begin
              if (pressed(merged[i].value) == pressed(held[n].value)) begin
                merged[i].value = held[n].value;
                absorbed = 1;
              end
              break;
            end
          end
        end
        if (!absorbed && merged.size() < STORE_DEPTH) merged = {merged, held[n]};
      end
      held.delete();
      foreach (merged[n]) begin
        res.ev = merged[n];
        res.last = (n == merged.size() - 1);
        awaited = {awaited, res};
      end
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(trig_event_t got, logic last);
      flush_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: kind %0d channel %0d number %0d value %0d last %0d",
                 $time, got.kind, got.channel, got.number, got.value, last);
        return;
      end
      want = awaited.pop_front();
      field_check("event_kind", 8'(want.ev.kind), 8'(got.kind));
      field_check("event_channel", 8'(want.ev.channel), 8'(got.channel));
      field_check("event_number", 8'(want.ev.number), 8'(got.number));
      field_check("event_value", 8'(want.ev.value), 8'(got.value));
      field_check("last_event", 8'(want.last), 8'(last));
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       cmd_i = CMD_PUSH;
  logic [7:0] status_byte_i = '0;
  logic [6:0] data_one_i = '0;
  logic [6:0] data_two_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] event_kind_o;
  logic [4:0] event_channel_o;
  logic [6:0] event_number_o;
  logic [6:0] event_value_o;
  logic       last_event_o;

  coalesce_scoreboard sb = new();

  int burst_left = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int counted = 0;

  midi_trigger_event_coalescer_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .status_byte_i  (status_byte_i),
    .data_one_i     (data_one_i),
    .data_two_i     (data_two_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .event_channel_o(event_channel_o),
    .event_number_o (event_number_o),
    .event_value_o  (event_value_o),
    .last_event_o   (last_event_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin : out_monitor
    trig_event_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind = event_kind_o;
      got.channel = event_channel_o;
      got.number = event_number_o;
      got.value = event_value_o;
      sb.check_result(got, last_event_o);
    end
  end

  // receiver pacing: modes of random length, plus long hold-offs on request
  initial begin : rx_pacing
    rx_mode_e mode;
    int       mode_left;
    mode = RX_STEADY;
    mode_left = 0;
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          RX_STEADY: out_ready_i <= 1'b1;
          RX_HALF:   out_ready_i <= 1'($urandom_range(0, 1));
          default:   out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #TIMEOUT;
    $display("FAIL midi_trigger_event_coalescer_top");
    $finish;
  end

  task automatic send_item(input logic c, input logic [7:0] s, input logic [6:0] a,
                           input logic [6:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    cmd_i <= c;
    status_byte_i <= s;
    data_one_i <= a;
    data_two_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(c, s, a, b);
    burst_left--;
    counted++;
  endtask

  task automatic flush_store();
    send_item(CMD_FLUSH, 8'($urandom), 7'($urandom), 7'($urandom));
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [7:0] v);
    pause_until_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.threshold = v;
  endtask

  // mostly kept messages on few channels and controllers so that coalescing happens
  task automatic push_random();
    logic [7:0] s;
    logic [6:0] a, b;
    int         pick, thr, lo, hi;
    pick = $urandom_range(0, 11);
    thr = sb.threshold;
    lo = (thr > 2) ? thr - 2 : 0;
    lo = (lo > 127) ? 127 : lo;
    hi = (thr + 1 > 127) ? 127 : thr + 1;
    s[3:0] = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 1))
                                         : 4'($urandom_range(0, 15));
    a = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, 2)) : 7'($urandom_range(0, 127));
    b = ($urandom_range(0, 2) == 0) ? 7'($urandom_range(lo, hi)) : 7'($urandom_range(0, 127));
    if (pick < 7) begin
      s[7:4] = MSG_CC;
    end else if (pick == 7) begin
      s[7:4] = MSG_PC;
    end else if (pick < 10) begin
      s[7:4] = MSG_NOTE_ON;
      if ($urandom_range(0, 7) == 0) b = '0;
    end else begin
      s = 8'($urandom);
      a = 7'($urandom);
      b = 7'($urandom);
    end
    send_item(CMD_PUSH, s, a, b);
  endtask

  initial begin : stimulus
    logic [7:0] extremes[5];
    int         phase, n_push;
    extremes = '{8'd0, 8'd128, 8'd127, 8'd1, 8'd255};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset threshold
    send_item(CMD_PUSH, {MSG_CC, 4'h0}, 7'd0, 7'd0);
    send_item(CMD_PUSH, {MSG_CC, 4'h0}, 7'd0, 7'd10);     // both released: overwrite
    send_item(CMD_PUSH, {MSG_CC, 4'h0}, 7'd0, 7'd64);     // crosses threshold: append
    send_item(CMD_PUSH, {MSG_CC, 4'h0}, 7'd0, 7'd127);    // both pressed: overwrite
    send_item(CMD_PUSH, {MSG_PC, 4'hF}, 7'd127, 7'd55);   // program change keeps no value
    send_item(CMD_PUSH, {MSG_NOTE_ON, 4'hF}, 7'd127, 7'd127);
    send_item(CMD_PUSH, {MSG_NOTE_ON, 4'h5}, 7'd60, 7'd0); // zero velocity: ignored
    send_item(CMD_PUSH, 8'h85, 7'd60, 7'd100);            // note-off
    send_item(CMD_PUSH, 8'hA3, 7'd1, 7'd2);               // poly aftertouch
    send_item(CMD_PUSH, 8'hD3, 7'd1, 7'd2);               // channel pressure
    send_item(CMD_PUSH, 8'hE0, 7'd127, 7'd127);           // pitch bend
    send_item(CMD_PUSH, 8'hF8, 7'd0, 7'd0);               // system message
    send_item(CMD_PUSH, 8'h3F, 7'd5, 7'd5);               // data byte as status
    send_item(CMD_PUSH, {MSG_CC, 4'hF}, 7'd127, 7'd127);
    send_item(CMD_PUSH, {MSG_CC, 4'h0}, 7'd1, 7'd5);      // other controller in between
    send_item(CMD_PUSH, {MSG_CC, 4'h0}, 7'd0, 7'd1);      // released after pressed: append
    send_item(CMD_PUSH, {MSG_CC, 4'h0}, 7'd0, 7'd0);      // newest entry, both released: overwrite
    send_item(CMD_FLUSH, 8'hFF, 7'h7F, 7'h7F);
    send_item(CMD_FLUSH, 8'h00, 7'h00, 7'h00);            // empty flush
    send_item(CMD_PUSH, {MSG_NOTE_ON, 4'h0}, 7'd0, 7'd1);
    flush_store();

    // random phases, each ending in a flush
    phase = 0;
    while (counted < RANDOM_ITEMS || phase <= HOLD_PHASE + 1) begin
      if (phase % 2 == 0 && phase != HOLD_PHASE + 1)
        write_threshold((phase / 2 < 5) ? extremes[phase / 2] : 8'($urandom_range(0, 128)));
      if (phase == 1 || phase == HOLD_PHASE || $urandom_range(0, 7) == 0)
        n_push = $urandom_range(33, 36);
      else n_push = $urandom_range(0, 8);
      repeat (n_push) push_random();
      // hold the receiver off while the sender keeps going into the next phase
      if (phase == HOLD_PHASE) hold_requests <= hold_requests + 1;
      flush_store();
      phase++;
    end

    pause_until_drained();
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("PASS midi_trigger_event_coalescer_top");
    end else begin
      $display("FAIL midi_trigger_event_coalescer_top");
    end
    $finish;
  end

endmodule
